[rtl/pbfs_pkg.sv]
// Package: operation codes, controller states and controller/datapath interface types
`timescale 1ns / 1ps

package pbfs_pkg;

    localparam int WORD_BITS = 32;
    localparam int BIT_IDX_W = 13;
    localparam int WIDX_W    = 8;
    localparam int SH_W      = 6;
    localparam int FW_W      = 5;

    typedef enum logic [1:0] {
        OP_READ_FIELD  = 2'd0,
        OP_WRITE_FIELD = 2'd1,
        OP_READ_WORD   = 2'd2,
        OP_WRITE_WORD  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_WR1
    } t_state;

    typedef struct packed {
        logic clear;
        logic accept;
        logic exec;
        logic wr1;
    } t_dp_cmd;

    typedef struct packed {
        logic clear_last;
        logic two_wr;
    } t_dp_sts;

endpackage

[rtl/packet_bit_field_store.sv]
// Top level: packet buffer with MSB-first bit field read/write and whole-word access
// Beats are registered on acceptance; the result is registered when the execute
// step runs, which waits while a presented result is stalled. A new beat is taken
// only when idle; a field write spanning two words adds a second write step, set
// by the single memory write port. Reads use two memory read ports. Reset: a
// clearing pass zeroes all BUFFER_WORDS words, one per cycle, stalling input.
`timescale 1ns / 1ps

module packet_bit_field_store
    import pbfs_pkg::*;
#(
    parameter int BUFFER_WORDS = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [1:0]           i_operation,
    input  logic [BIT_IDX_W-1:0] i_start_bit,
    input  logic [BIT_IDX_W-1:0] i_end_bit,
    input  logic [WIDX_W-1:0]    i_word_index,
    input  logic [WORD_BITS-1:0] i_write_data,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [WORD_BITS-1:0] o_read_data,
    output logic                 o_field_error
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    pbfs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    pbfs_dp #(
        .BUFFER_WORDS (BUFFER_WORDS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_operation   (i_operation),
        .i_start_bit   (i_start_bit),
        .i_end_bit     (i_end_bit),
        .i_word_index  (i_word_index),
        .i_write_data  (i_write_data),
        .o_read_data   (o_read_data),
        .o_field_error (o_field_error)
    );

endmodule

[rtl/pbfs_ctrl.sv]
// Controller: clearing pass, beat acceptance, execute sequencing and output valid
`timescale 1ns / 1ps

module pbfs_ctrl
    import pbfs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    output logic    o_valid,
    input  logic    i_stall,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!r_out_valid || !i_stall) begin
                    o_cmd.exec = 1'b1;
                    n_state    = i_sts.two_wr ? S_WR1 : S_IDLE;
                end
            end
            S_WR1: begin
                o_cmd.wr1 = 1'b1;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.exec) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

endmodule

[rtl/pbfs_dp.sv]
// Datapath: packet word memory, field decode, extract/insert and result registers
`timescale 1ns / 1ps

module pbfs_dp
    import pbfs_pkg::*;
#(
    parameter int BUFFER_WORDS = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    output t_dp_sts              o_sts,
    input  logic [1:0]           i_operation,
    input  logic [BIT_IDX_W-1:0] i_start_bit,
    input  logic [BIT_IDX_W-1:0] i_end_bit,
    input  logic [WIDX_W-1:0]    i_word_index,
    input  logic [WORD_BITS-1:0] i_write_data,
    output logic [WORD_BITS-1:0] o_read_data,
    output logic                 o_field_error
);

    localparam int AW  = $clog2(BUFFER_WORDS);
    localparam int CMP = 18;

    logic [WORD_BITS-1:0] mem [BUFFER_WORDS];

    logic [AW-1:0]        r_clr_cnt;
    t_op                  r_op;
    logic [AW-1:0]        r_a0, r_a1;
    logic                 r_two, r_err, r_inrange;
    logic [SH_W-1:0]      r_sh;
    logic [FW_W-1:0]      r_wm1;
    logic [WORD_BITS-1:0] r_data, r_rd0, r_rd1, r_lo;
    logic [WORD_BITS-1:0] r_res;
    logic                 r_res_err;

    t_op                  in_op;
    logic                 in_word;
    logic [WIDX_W-1:0]    w0_idx, w1_idx;
    logic [BIT_IDX_W-1:0] diff;
    logic                 f_ok, two;
    logic [AW-1:0]        ra0, ra1;

    logic [2*WORD_BITS-1:0] window, fmask, fins, nwin;
    logic [WORD_BITS-1:0]   mask, field;
    logic [WORD_BITS-1:0]   n_res;
    logic                   n_res_err;
    logic                   we;
    logic [AW-1:0]          wa;
    logic [WORD_BITS-1:0]   wd;

    // Decode at acceptance
    always_comb begin
        in_op   = t_op'(i_operation);
        in_word = (in_op == OP_READ_WORD) || (in_op == OP_WRITE_WORD);
        w0_idx  = i_start_bit[BIT_IDX_W-1:FW_W];
        w1_idx  = i_end_bit[BIT_IDX_W-1:FW_W];
        diff    = i_end_bit - i_start_bit;
        f_ok    = (i_end_bit >= i_start_bit) && (diff[BIT_IDX_W-1:FW_W] == '0)
                  && (CMP'(w1_idx) < CMP'(BUFFER_WORDS));
        two     = (w0_idx != w1_idx);
        ra0     = in_word ? AW'(i_word_index) : AW'(w0_idx);
        ra1     = AW'(w1_idx);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op      <= in_op;
            r_a0      <= ra0;
            r_a1      <= ra1;
            r_two     <= two;
            r_err     <= !f_ok;
            r_inrange <= (CMP'(i_word_index) < CMP'(BUFFER_WORDS));
            r_sh      <= SH_W'(63) - {two, i_end_bit[FW_W-1:0]};
            r_wm1     <= diff[FW_W-1:0];
            r_data    <= i_write_data;
            r_rd0     <= mem[ra0];
            r_rd1     <= mem[ra1];
        end
    end

    // Field extract and insert over the two-word window
    always_comb begin
        window = {r_rd0, (r_two ? r_rd1 : {WORD_BITS{1'b0}})};
        mask   = {WORD_BITS{1'b1}} >> (FW_W'(WORD_BITS - 1) - r_wm1);
        field  = WORD_BITS'(window >> r_sh) & mask;
        fmask  = {{WORD_BITS{1'b0}}, mask} << r_sh;
        fins   = {{WORD_BITS{1'b0}}, r_data & mask} << r_sh;
        nwin   = (window & ~fmask) | fins;

        n_res     = '0;
        n_res_err = 1'b0;
        case (r_op)
            OP_READ_FIELD: begin
                n_res_err = r_err;
                n_res     = r_err ? '0 : field;
            end
            OP_WRITE_FIELD: begin
                n_res_err = r_err;
            end
            OP_READ_WORD: begin
                n_res = r_inrange ? r_rd0 : '0;
            end
            default: begin
                n_res = '0;
            end
        endcase
    end

    // Memory write port
    always_comb begin
        we = 1'b0;
        wa = r_a0;
        wd = r_data;
        if (i_cmd.clear) begin
            we = 1'b1;
            wa = r_clr_cnt;
            wd = '0;
        end else if (i_cmd.exec) begin
            if (r_op == OP_WRITE_FIELD) begin
                we = !r_err;
                wd = nwin[2*WORD_BITS-1:WORD_BITS];
            end else if (r_op == OP_WRITE_WORD) begin
                we = r_inrange;
            end
        end else if (i_cmd.wr1) begin
            we = 1'b1;
            wa = r_a1;
            wd = r_lo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.clear) begin
            r_clr_cnt <= r_clr_cnt + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_res     <= n_res;
            r_res_err <= n_res_err;
            r_lo      <= nwin[WORD_BITS-1:0];
        end
    end

    assign o_sts.clear_last = (r_clr_cnt == AW'(BUFFER_WORDS - 1));
    assign o_sts.two_wr     = (r_op == OP_WRITE_FIELD) && !r_err && r_two;
    assign o_read_data      = r_res;
    assign o_field_error    = r_res_err;

endmodule

[dv/pbfs_checker.sv]
// Checker: predicts the packet bit field store and compares every result beat
`timescale 1ns / 1ps

module pbfs_checker
    import pbfs_pkg::*;
#(
    parameter int BUFFER_WORDS = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  logic [1:0]           i_operation,
    input  logic [BIT_IDX_W-1:0] i_start_bit,
    input  logic [BIT_IDX_W-1:0] i_end_bit,
    input  logic [WIDX_W-1:0]    i_word_index,
    input  logic [WORD_BITS-1:0] i_write_data,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  logic [WORD_BITS-1:0] i_read_data,
    input  logic                 i_field_error,
    output int                   o_fail_count,
    output int                   o_pending
);

    typedef struct packed {
        logic [WORD_BITS-1:0] read_data;
        logic                 field_error;
    } t_result;

    logic [WORD_BITS-1:0] packet_mem [BUFFER_WORDS];
    t_result              pending_results [$];

    // MSB-first numbering: bit 0 is bit 31 of word 0
    function automatic t_result apply_beat(t_op op, logic [BIT_IDX_W-1:0] sb,
                                           logic [BIT_IDX_W-1:0] eb,
                                           logic [WIDX_W-1:0] wi,
                                           logic [WORD_BITS-1:0] wd);
        t_result     res;
        int          s, e, width, w0, w1, sh;
        logic [63:0] window, mask, fmask;
        res = '0;
        s = int'(sb);
        e = int'(eb);
        if (op == OP_READ_WORD || op == OP_WRITE_WORD) begin
            if (int'(wi) < BUFFER_WORDS) begin
                if (op == OP_READ_WORD) res.read_data = packet_mem[wi];
                else packet_mem[wi] = wd;
            end
        end else if (e < s || e - s + 1 > 32 || (e >> 5) >= BUFFER_WORDS) begin
            res.field_error = 1'b1;
        end else begin
            w0     = s >> 5;
            w1     = e >> 5;
            width  = e - s + 1;
            sh     = 63 - (e - (w0 << 5));
            window = {packet_mem[w0], (w0 != w1) ? packet_mem[w1] : 32'h0};
            mask   = (width >= 32) ? 64'hFFFF_FFFF : ((64'd1 << width) - 64'd1);
            if (op == OP_READ_FIELD) begin
                res.read_data = 32'((window >> sh) & mask);
            end else begin
                fmask  = mask << sh;
                window = (window & ~fmask) | ((64'(wd) & mask) << sh);
                packet_mem[w0] = window[63:32];
                if (w0 != w1) packet_mem[w1] = window[31:0];
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            foreach (packet_mem[k]) packet_mem[k] = '0;
            pending_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    o_fail_count++;
                    $display("%0t pbfs_checker: unexpected result beat read_data %h error %b",
                             $time, i_read_data, i_field_error);
                end else begin
                    want = pending_results.pop_front();
                    if (i_read_data !== want.read_data) begin
                        o_fail_count++;
                        $display("%0t pbfs_checker: read_data expected %h actual %h",
                                 $time, want.read_data, i_read_data);
                    end
                    if (i_field_error !== want.field_error) begin
                        o_fail_count++;
                        $display("%0t pbfs_checker: field_error expected %b actual %b",
                                 $time, want.field_error, i_field_error);
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                pending_results.push_back(apply_beat(t_op'(i_operation), i_start_bit,
                                                     i_end_bit, i_word_index, i_write_data));
        end
        o_pending = pending_results.size();
    end

endmodule

[dv/tb_top.sv]
// Testbench top: stimulus, flow control and verdict for the packet bit field store
`timescale 1ns / 1ps

module tb_top;
    import pbfs_pkg::*;

    localparam int BUFFER_WORDS = 256;
    localparam int PHASE_BEATS  = 633;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic [1:0]           i_operation;
    logic [BIT_IDX_W-1:0] i_start_bit;
    logic [BIT_IDX_W-1:0] i_end_bit;
    logic [WIDX_W-1:0]    i_word_index;
    logic [WORD_BITS-1:0] i_write_data;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic [WORD_BITS-1:0] o_read_data;
    logic                 o_field_error;

    int          fail_count;
    int          pending;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    packet_bit_field_store #(.BUFFER_WORDS(BUFFER_WORDS)) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_operation   (i_operation),
        .i_start_bit   (i_start_bit),
        .i_end_bit     (i_end_bit),
        .i_word_index  (i_word_index),
        .i_write_data  (i_write_data),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_read_data   (o_read_data),
        .o_field_error (o_field_error)
    );

    pbfs_checker #(.BUFFER_WORDS(BUFFER_WORDS)) i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_stall    (o_stall),
        .i_operation   (i_operation),
        .i_start_bit   (i_start_bit),
        .i_end_bit     (i_end_bit),
        .i_word_index  (i_word_index),
        .i_write_data  (i_write_data),
        .i_out_valid   (o_valid),
        .i_out_stall   (i_stall),
        .i_read_data   (o_read_data),
        .i_field_error (o_field_error),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    initial begin
        #2_000_000;
        $display("tb_top: errors");
        $finish;
    end

    // called and returns at a falling edge; valid stays high into the next call
    task automatic drive_beat(t_op op, int sb, int eb, int wi, logic [WORD_BITS-1:0] wd);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_operation  <= op;
        i_start_bit  <= BIT_IDX_W'(sb);
        i_end_bit    <= BIT_IDX_W'(eb);
        i_word_index <= WIDX_W'(wi);
        i_write_data <= wd;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic random_beat();
        t_op                  op;
        int                   sb, eb, wi, width, hi_bit, shape;
        logic [WORD_BITS-1:0] wd;
        op     = t_op'($urandom_range(3));
        shape  = $urandom_range(99);
        hi_bit = ($urandom_range(1) == 0) ? 255 : 8191;
        wi     = ($urandom_range(1) == 0) ? $urandom_range(7) : $urandom_range(255);
        case ($urandom_range(3))
            0:       wd = '0;
            1:       wd = '1;
            default: wd = $urandom;
        endcase
        if (shape < 82) begin
            if ($urandom_range(4) == 0) width = ($urandom_range(1) == 0) ? 1 : 32;
            else width = $urandom_range(1, 32);
            sb = $urandom_range(0, hi_bit - width + 1);
            eb = sb + width - 1;
        end else if (shape < 91) begin
            sb = $urandom_range(1, hi_bit);
            eb = $urandom_range(0, sb - 1);
        end else if (shape < 96) begin
            sb = $urandom_range(0, hi_bit - 32);
            eb = $urandom_range(sb + 32, hi_bit);
        end else begin
            sb = $urandom_range(8191);
            eb = $urandom_range(8191);
        end
        drive_beat(op, sb, eb, wi, wd);
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_operation  = OP_READ_FIELD;
        i_start_bit  = '0;
        i_end_bit    = '0;
        i_word_index = '0;
        i_write_data = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        drive_beat(OP_READ_FIELD,  0,    31,   200, 32'hDEAD_BEEF);
        drive_beat(OP_WRITE_FIELD, 0,    31,   0,   32'hFFFF_FFFF);
        drive_beat(OP_WRITE_FIELD, 8160, 8191, 9,   32'hA5A5_A5A5);
        drive_beat(OP_READ_FIELD,  8160, 8191, 0,   32'h0);
        drive_beat(OP_WRITE_FIELD, 20,   51,   0,   32'h1234_5678);
        drive_beat(OP_READ_FIELD,  20,   51,   0,   32'h0);
        drive_beat(OP_READ_WORD,   0,    0,    1,   32'h0);
        drive_beat(OP_WRITE_FIELD, 8191, 8191, 0,   32'hFFFF_FFFE);
        drive_beat(OP_WRITE_FIELD, 8190, 8190, 0,   32'hFFFF_FFFF);
        drive_beat(OP_READ_FIELD,  8188, 8191, 0,   32'h0);
        drive_beat(OP_WRITE_FIELD, 40,   47,   0,   32'hFFFF_FF00);
        drive_beat(OP_READ_FIELD,  32,   63,   0,   32'h0);
        drive_beat(OP_WRITE_FIELD, 100,  99,   0,   32'hFFFF_FFFF);
        drive_beat(OP_READ_FIELD,  8191, 0,    0,   32'h0);
        drive_beat(OP_WRITE_FIELD, 0,    32,   0,   32'h0);
        drive_beat(OP_READ_FIELD,  8159, 8191, 0,   32'h0);
        drive_beat(OP_READ_WORD,   0,    0,    0,   32'h0);
        drive_beat(OP_WRITE_WORD,  8191, 0,    255, 32'hFFFF_FFFF);
        drive_beat(OP_READ_WORD,   123,  4567, 255, 32'h5555_5555);
        drive_beat(OP_WRITE_WORD,  0,    31,   0,   32'h0);
        drive_beat(OP_READ_WORD,   0,    0,    0,   32'h0);
        drive_beat(OP_READ_FIELD,  8160, 8191, 77,  32'h0);
        drive_beat(OP_READ_WORD,   0,    0,    128, 32'h0);

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 23 : (phase == 1) ? 59 : 0;
            recv_idle_pct = (phase == 0) ? 59 : (phase == 1) ? 23 : 0;
            repeat (PHASE_BEATS) random_beat();
        end
        i_valid <= 1'b0;

        do @(negedge i_clk); while (pending != 0);
        repeat (8) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/pbfs_pkg.sv
rtl/pbfs_ctrl.sv
rtl/pbfs_dp.sv
rtl/packet_bit_field_store.sv
dv/pbfs_checker.sv
dv/tb_top.sv
